// File: design/led_blink_refresh_controller_unit_assert.svh
// ---------------------------------------------------------------------------
// LED blink/refresh controller assertion macros
// Concurrent check helpers; they compile to nothing when SYNTHESIS is set.
// ---------------------------------------------------------------------------
`ifndef LED_BLINK_REFRESH_CONTROLLER_UNIT_ASSERT_SVH
`define LED_BLINK_REFRESH_CONTROLLER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define LBRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lbrc assertion failed");
// next-cycle implication
`define LBRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lbrc assertion failed");
`else
`define LBRC_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LBRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// File: design/lbrc_pkg.sv
// ---------------------------------------------------------------------------
// LED blink/refresh controller package
// Request codes, register indexes and reset periods.
// ---------------------------------------------------------------------------
package lbrc_pkg;

	localparam int PatternWidth = 7;
	localparam int IndexWidth   = 3;
	localparam int CountWidth   = 16;
	localparam int CfgIdxWidth  = 8;

	localparam logic [CountWidth-1:0] REFRESH_PERIOD_RST = 16'd10;
	localparam logic [CountWidth-1:0] BLINK_PERIOD_RST   = 16'd500;

	// configuration register indexes
	localparam logic [CfgIdxWidth-1:0] CFG_REFRESH_PERIOD = 8'd0;
	localparam logic [CfgIdxWidth-1:0] CFG_BLINK_PERIOD   = 8'd1;

	typedef enum logic [3:0] {
		REQ_TICK          = 4'd0,
		REQ_ON            = 4'd1,
		REQ_OFF           = 4'd2,
		REQ_BLINK_ON      = 4'd3,
		REQ_BLINK_OFF     = 4'd4,
		REQ_ALL_ON        = 4'd5,
		REQ_ALL_OFF       = 4'd6,
		REQ_ALL_BLINK_ON  = 4'd7,
		REQ_ALL_BLINK_OFF = 4'd8
	} req_t;

endpackage

// File: design/led_blink_refresh_controller_unit.sv
// ---------------------------------------------------------------------------
// LED blink/refresh controller
// Per-LED steady, blink-enable and image bits; ticks drive a refresh counter
// that latches images onto the pattern and a blink counter that flashes LEDs.
// ---------------------------------------------------------------------------
// channel | signals                              | direction
// in      | in_valid/in_ready, req_type, led_index | beat in
// out     | out_valid/out_ready, led_pattern     | beat out
// cfg     | cfg_valid/cfg_ready, cfg_index, cfg_data | register write
//
// One beat per clock while out_ready holds; an accepted beat passes through the
// input register, then the state update into the result register.
// cfg_ready is always high; writes land in the period registers and take
// effect at the next counter reload.
// Reset restores default periods, loads counters and clears all LED bits.
// A stalled result holds the update stage; the input register still takes a
// beat while the update stage is free or advancing.
// ---------------------------------------------------------------------------
`include "led_blink_refresh_controller_unit_assert.svh"

module led_blink_refresh_controller_unit
	import lbrc_pkg::*;
#(
	parameter int NUM_LEDS = 7
) (
	input  logic                    clk,
	input  logic                    arst_n,
	// request channel
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [3:0]              req_type,
	input  logic [IndexWidth-1:0]   led_index,
	// result channel
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [PatternWidth-1:0] led_pattern,
	// configuration channel
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CfgIdxWidth-1:0]  cfg_index,
	input  logic [CountWidth-1:0]   cfg_data
);

	localparam logic [NUM_LEDS-1:0] LedMask = '1;

	// input register
	logic                  valid_s1;
	req_t                  req_s1;
	logic [IndexWidth-1:0] idx_s1;

	// state
	logic [CountWidth-1:0] refresh_period_q, blink_period_q;
	logic [CountWidth-1:0] refresh_count_q, blink_count_q;
	logic                  phase_q;
	logic [NUM_LEDS-1:0]   steady_q, enables_q, image_q, shown_q;

	logic [CountWidth-1:0] refresh_count_d, blink_count_d;
	logic                  phase_d;
	logic [NUM_LEDS-1:0]   steady_d, enables_d, image_d, shown_d;

	logic                  out_valid_q;
	logic [PatternWidth-1:0] pattern_q, pattern_d;

	logic                  advance, fire;
	logic [NUM_LEDS-1:0]   sel_bit;
	logic [CountWidth-1:0] refresh_dec, blink_dec;

	assign advance   = !out_valid_q || out_ready;
	assign fire      = valid_s1 && advance;
	assign in_ready  = !valid_s1 || advance;
	assign cfg_ready = 1'b1;
	assign out_valid   = out_valid_q;
	assign led_pattern = pattern_q;

	// one-hot LED select, empty when the index is out of range
	assign sel_bit = (int'(idx_s1) < NUM_LEDS) ?
		(NUM_LEDS'(1) << idx_s1) : '0;

	assign refresh_dec = refresh_count_q - 1'b1;
	assign blink_dec   = blink_count_q - 1'b1;

	// next state for the request in the input register
	always_comb begin
		refresh_count_d = refresh_count_q;
		blink_count_d   = blink_count_q;
		phase_d         = phase_q;
		steady_d        = steady_q;
		enables_d       = enables_q;
		image_d         = image_q;
		shown_d         = shown_q;
		unique case (req_s1)
			REQ_TICK: begin
				// refresh first: latch the image from before this tick's blink
				refresh_count_d = refresh_dec;
				if (refresh_dec == '0) begin
					refresh_count_d = refresh_period_q;
					shown_d         = image_q;
				end
				blink_count_d = blink_dec;
				if (blink_dec == '0) begin
					blink_count_d = blink_period_q;
					image_d = phase_q ? (image_q | enables_q) : (image_q & ~enables_q);
					phase_d = !phase_q;
				end
			end
			REQ_ON: begin
				image_d  = image_q | sel_bit;
				steady_d = steady_q | sel_bit;
			end
			REQ_OFF: begin
				image_d  = image_q & ~sel_bit;
				steady_d = steady_q & ~sel_bit;
			end
			REQ_BLINK_ON: enables_d = enables_q | sel_bit;
			REQ_BLINK_OFF: begin
				enables_d = enables_q & ~sel_bit;
				image_d   = (image_q & ~sel_bit) | (steady_q & sel_bit);
			end
			REQ_ALL_ON: begin
				image_d  = LedMask;
				steady_d = LedMask;
			end
			REQ_ALL_OFF: begin
				image_d  = '0;
				steady_d = '0;
			end
			REQ_ALL_BLINK_ON: enables_d = LedMask;
			REQ_ALL_BLINK_OFF: begin
				enables_d = '0;
				image_d   = steady_q;
			end
			default: ;
		endcase
	end

	// map latched bits onto the fixed-width pattern
	always_comb begin
		pattern_d = '0;
		for (int i = 0; i < PatternWidth; i++) begin
			if (i < NUM_LEDS) pattern_d[i] = shown_d[i % NUM_LEDS];
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			req_s1 <= req_t'(req_type);
			idx_s1 <= led_index;
		end
	end

	// period registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_period_q <= REFRESH_PERIOD_RST;
			blink_period_q   <= BLINK_PERIOD_RST;
		end else if (cfg_valid) begin
			if (cfg_index == CFG_REFRESH_PERIOD) refresh_period_q <= cfg_data;
			if (cfg_index == CFG_BLINK_PERIOD)   blink_period_q   <= cfg_data;
		end
	end

	// LED state and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			refresh_count_q <= REFRESH_PERIOD_RST;
			blink_count_q   <= BLINK_PERIOD_RST;
			phase_q         <= 1'b0;
			steady_q        <= '0;
			enables_q       <= '0;
			image_q         <= '0;
			shown_q         <= '0;
		end else if (fire) begin
			refresh_count_q <= refresh_count_d;
			blink_count_q   <= blink_count_d;
			phase_q         <= phase_d;
			steady_q        <= steady_d;
			enables_q       <= enables_d;
			image_q         <= image_d;
			shown_q         <= shown_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) pattern_q <= pattern_d;
	end

	// checks
	`LBRC_ASSERT_NEXT(a_refresh_latch, clk, arst_n, fire && req_s1 == REQ_TICK && refresh_count_q == 16'd1, shown_q == $past(image_q))
	`LBRC_ASSERT_IMP(a_steady_track, clk, arst_n, 1'b1, (image_q & ~enables_q) == (steady_q & ~enables_q))
	`LBRC_ASSERT_NEXT(a_fire_result, clk, arst_n, fire, out_valid_q)

endmodule
